@@ rtl/core/complex_matrix_multiply_herm_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the complex matrix multiply block
// Concurrent checks used by the block's modules; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_MATRIX_MULTIPLY_HERM_DEFINES_SVH
`define COMPLEX_MATRIX_MULTIPLY_HERM_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define CMMH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked out of reset
`define CMMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CMMH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define CMMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/core/cmmh_pkg.sv @@
// ----------------------------------------------------------------------------
// cmmh_pkg
// Shared widths, codes and types of the complex matrix multiply block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmmh_pkg;

	localparam int DEF_MAX_DIM    = 8;
	localparam int DEF_DATA_WIDTH = 16;

	localparam int SUM_W      = 36;  // exact product sum, wraps beyond
	localparam int ROW_W      = 3;   // out_row / out_col / elem_row / elem_col
	localparam int DIM_W      = 4;   // dimension registers
	localparam int LIM_W      = DIM_W + 1;  // room to compare against MAX_DIM
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = DIM_W;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

	localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HERM_A = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HERM_B = 3'd5;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} seq_state_t;

	typedef struct packed {
		logic [DIM_W-1:0] rows_a;
		logic [DIM_W-1:0] cols_a;
		logic [DIM_W-1:0] rows_b;
		logic [DIM_W-1:0] cols_b;
		logic             herm_a;
		logic             herm_b;
	} dims_t;

	// travels with each store read down the MAC pipeline
	typedef struct packed {
		logic             valid;
		logic             first;     // first term of a dot product
		logic             last_k;    // final term of a dot product
		logic             last_all;  // dot product is the final element of C
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col;
	} tag_t;

endpackage

`default_nettype wire

@@ rtl/core/cmmh_mem.sv @@
// ----------------------------------------------------------------------------
// cmmh_mem
// Matrix store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmmh_mem #(
	parameter int ADDR_W = 6,
	parameter int DATA_W = 32
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// hold read data while the pipeline stalls
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/cmmh_seq.sv @@
// ----------------------------------------------------------------------------
// cmmh_seq
// Walks i, j, l of the product; reads each store once a cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "complex_matrix_multiply_herm_defines.svh"

module cmmh_seq import cmmh_pkg::*; #(
	parameter int MAX_DIM = DEF_MAX_DIM,
	parameter int IDX_W   = $clog2(MAX_DIM)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               adv,
	input  wire dims_t              dims,
	output logic                    busy,
	output logic [2*IDX_W-1:0]      a_addr,
	output logic [2*IDX_W-1:0]      b_addr,
	output tag_t                    tag
);

	seq_state_t       state_q, state_d;
	logic [IDX_W-1:0] i_q, j_q, l_q;
	logic [IDX_W-1:0] i_d, j_d, l_d;
	logic [IDX_W-1:0] mlast, klast, nlast;
	logic [IDX_W-1:0] ra_last, ca_last, rb_last, cb_last;

	// clamp a dimension to 1..MAX_DIM and return it minus one
	function automatic logic [IDX_W-1:0] last_idx(input logic [DIM_W-1:0] d);
		logic [LIM_W-1:0] dw;
		dw = LIM_W'(d);
		if (d == '0) begin
			return '0;
		end else if (dw > LIM_W'(MAX_DIM)) begin
			return IDX_W'(MAX_DIM - 1);
		end else begin
			return IDX_W'(dw - LIM_W'(1));
		end
	endfunction

	assign ra_last = last_idx(dims.rows_a);
	assign ca_last = last_idx(dims.cols_a);
	assign rb_last = last_idx(dims.rows_b);
	assign cb_last = last_idx(dims.cols_b);

	assign mlast = dims.herm_a ? ca_last : ra_last;
	assign klast = dims.herm_a ? ra_last : ca_last;
	assign nlast = dims.herm_b ? rb_last : cb_last;

	// store address is {row, column}
	assign a_addr = dims.herm_a ? {l_q, i_q} : {i_q, l_q};
	assign b_addr = dims.herm_b ? {j_q, l_q} : {l_q, j_q};
	assign busy   = (state_q == ST_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			l_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			l_q     <= l_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		i_d          = i_q;
		j_d          = j_q;
		l_d          = l_q;
		tag.valid    = (state_q == ST_RUN);
		tag.first    = (l_q == '0);
		tag.last_k   = (l_q == klast);
		tag.last_all = (i_q == mlast) && (j_q == nlast);
		tag.row      = ROW_W'(i_q);
		tag.col      = ROW_W'(j_q);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_RUN;
					i_d     = '0;
					j_d     = '0;
					l_d     = '0;
				end
			end
			ST_RUN: begin
				if (adv) begin
					if (l_q != klast) begin
						l_d = l_q + 1'b1;
					end else begin
						l_d = '0;
						if (j_q != nlast) begin
							j_d = j_q + 1'b1;
						end else begin
							j_d = '0;
							if (i_q != mlast) begin
								i_d = i_q + 1'b1;
							end else begin
								state_d = ST_IDLE;
							end
						end
					end
				end
			end
		endcase
	end

	`CMMH_ASSERT_IMPL(a_start_idle, clk, arst_n, start, state_q == ST_IDLE, "start while running")
	`CMMH_ASSERT_IMPL(a_idx_bound, clk, arst_n, state_q == ST_RUN, (l_q <= klast) && (j_q <= nlast) && (i_q <= mlast), "index past its limit")
	`CMMH_ASSERT_NEXT(a_run_end, clk, arst_n, (state_q == ST_RUN) && adv && tag.last_k && tag.last_all, state_q == ST_IDLE, "run did not end after final read")

endmodule

`default_nettype wire

@@ rtl/core/cmmh_mac.sv @@
// ----------------------------------------------------------------------------
// cmmh_mac
// Conjugate, complex multiply, accumulate and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmmh_mac import cmmh_pkg::*; #(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    adv,
	input  wire logic                    herm_a,
	input  wire logic                    herm_b,
	input  wire tag_t                    tag_s0,
	input  wire logic [2*DATA_WIDTH-1:0] a_rd,
	input  wire logic [2*DATA_WIDTH-1:0] b_rd,
	output logic                         out_valid,
	output logic [ROW_W-1:0]             out_row,
	output logic [ROW_W-1:0]             out_col,
	output logic signed [SUM_W-1:0]      sum_re,
	output logic signed [SUM_W-1:0]      sum_im,
	output logic                         last
);

	localparam int PW = 2 * DATA_WIDTH;

	tag_t                         tag_s1, tag_s2, tag_s3;
	logic signed [DATA_WIDTH-1:0] xr, xi, yr, yi;
	logic signed [PW-1:0]         rr_s2, ii_s2, ri_s2, ir_s2;
	logic signed [SUM_W-1:0]      term_re_s3, term_im_s3;
	logic signed [SUM_W-1:0]      acc_re_q, acc_im_q;
	logic signed [SUM_W-1:0]      next_re, next_im;
	logic                         out_valid_q;
	logic [ROW_W-1:0]             out_row_q, out_col_q;
	logic signed [SUM_W-1:0]      sum_re_q, sum_im_q;
	logic                         last_q;

	// negate, with the most negative value going to the most positive
	function automatic logic signed [DATA_WIDTH-1:0] neg_sat(
		input logic signed [DATA_WIDTH-1:0] v
	);
		if (v == {1'b1, {(DATA_WIDTH-1){1'b0}}}) begin
			return {1'b0, {(DATA_WIDTH-1){1'b1}}};
		end else begin
			return -v;
		end
	endfunction

	assign xr = a_rd[PW-1:DATA_WIDTH];
	assign xi = herm_a ? neg_sat(a_rd[DATA_WIDTH-1:0]) : a_rd[DATA_WIDTH-1:0];
	assign yr = b_rd[PW-1:DATA_WIDTH];
	assign yi = herm_b ? neg_sat(b_rd[DATA_WIDTH-1:0]) : b_rd[DATA_WIDTH-1:0];

	assign next_re = (tag_s3.first ? '0 : acc_re_q) + term_re_s3;
	assign next_im = (tag_s3.first ? '0 : acc_im_q) + term_im_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1      <= '0;
			tag_s2      <= '0;
			tag_s3      <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			tag_s1      <= tag_s0;
			tag_s2      <= tag_s1;
			tag_s3      <= tag_s2;
			out_valid_q <= tag_s3.valid && tag_s3.last_k;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rr_s2      <= xr * yr;
			ii_s2      <= xi * yi;
			ri_s2      <= xr * yi;
			ir_s2      <= xi * yr;
			term_re_s3 <= SUM_W'(rr_s2) - SUM_W'(ii_s2);
			term_im_s3 <= SUM_W'(ri_s2) + SUM_W'(ir_s2);
			if (tag_s3.valid) begin
				acc_re_q <= next_re;
				acc_im_q <= next_im;
			end
			if (tag_s3.valid && tag_s3.last_k) begin
				out_row_q <= tag_s3.row;
				out_col_q <= tag_s3.col;
				sum_re_q  <= next_re;
				sum_im_q  <= next_im;
				last_q    <= tag_s3.last_all;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign sum_re    = sum_re_q;
	assign sum_im    = sum_im_q;
	assign last      = last_q;

endmodule

`default_nettype wire

@@ rtl/core/complex_matrix_multiply_herm.sv @@
// ----------------------------------------------------------------------------
// complex_matrix_multiply_herm
// Complex matrix product C = op(A) * op(B), op either identity or conjugate
// transpose. Load transactions (cmd load A / load B) write one Q1.15 element
// of a store at (elem_row, elem_col), a new one whenever the input is not
// stalled; writes outside the MAX_DIM x MAX_DIM store are dropped. A compute
// transaction walks C in row-major order and emits one result transaction per
// element, the final one with last set. Shape: m = herm_a ? cols_a : rows_a,
// inner length k = herm_a ? rows_a : cols_a, n = herm_b ? rows_b : cols_b,
// each dimension clamped to 1..MAX_DIM. A compute transaction keeps the input
// stalled while its run issues the store reads, one per complex
// multiply-accumulate in a single MAC fed by one read port of each store.
// Results leave a four-stage pipeline (store read, multiply, combine,
// accumulate); a stalled output freezes the whole pipeline. Sums are exact
// signed Q6.30 in 36 bits and wrap beyond that. Configuration goes in
// through a plain write port and must only change while no results are
// outstanding. Store contents are undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "complex_matrix_multiply_herm_defines.svh"

module complex_matrix_multiply_herm import cmmh_pkg::*; #(
	parameter int MAX_DIM    = DEF_MAX_DIM,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration write port
	input  wire logic                         cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_DATA_W-1:0]        cfg_data,
	// input channel
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [CMD_W-1:0]             cmd,
	input  wire logic [ROW_W-1:0]             elem_row,
	input  wire logic [ROW_W-1:0]             elem_col,
	input  wire logic signed [DATA_WIDTH-1:0] elem_re,
	input  wire logic signed [DATA_WIDTH-1:0] elem_im,
	// output channel
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [ROW_W-1:0]                  out_row,
	output logic [ROW_W-1:0]                  out_col,
	output logic signed [SUM_W-1:0]           sum_re,
	output logic signed [SUM_W-1:0]           sum_im,
	output logic                              last
);

	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int ADDR_W = 2 * IDX_W;
	localparam int ELEM_W = 2 * DATA_WIDTH;

	dims_t               dims_q;
	logic                in_accept;
	logic                start;
	logic                busy;
	logic                adv;
	logic                wr_ok;
	logic                mem_a_we, mem_b_we;
	logic [ADDR_W-1:0]   wr_addr;
	logic [ELEM_W-1:0]   wr_data;
	logic [ADDR_W-1:0]   a_addr, b_addr;
	logic [ELEM_W-1:0]   a_rd, b_rd;
	tag_t                tag_s0;

	// Configuration registers; unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q.rows_a <= DIM_RESET;
			dims_q.cols_a <= DIM_RESET;
			dims_q.rows_b <= DIM_RESET;
			dims_q.cols_b <= DIM_RESET;
			dims_q.herm_a <= 1'b0;
			dims_q.herm_b <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_ROWS_A: dims_q.rows_a <= cfg_data;
				REG_COLS_A: dims_q.cols_a <= cfg_data;
				REG_ROWS_B: dims_q.rows_b <= cfg_data;
				REG_COLS_B: dims_q.cols_b <= cfg_data;
				REG_HERM_A: dims_q.herm_a <= cfg_data[0];
				REG_HERM_B: dims_q.herm_b <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Take loads and compute commands only while no run is issuing reads,
	// so a store is never written while a run reads it.
	assign in_stall  = busy;
	assign in_accept = in_valid && !in_stall;
	assign start     = in_accept && (cmd == CMD_COMPUTE);

	// Drop writes that fall outside the store.
	assign wr_ok    = (LIM_W'(elem_row) < LIM_W'(MAX_DIM)) &&
	                  (LIM_W'(elem_col) < LIM_W'(MAX_DIM));
	assign mem_a_we = in_accept && (cmd == CMD_LOAD_A) && wr_ok;
	assign mem_b_we = in_accept && (cmd == CMD_LOAD_B) && wr_ok;
	assign wr_addr  = {IDX_W'(elem_row), IDX_W'(elem_col)};
	assign wr_data  = {elem_re, elem_im};

	// Advance the pipeline whenever the output register is free or emptying.
	assign adv = !out_valid || !out_stall;

	cmmh_seq #(
		.MAX_DIM (MAX_DIM),
		.IDX_W   (IDX_W)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.adv    (adv),
		.dims   (dims_q),
		.busy   (busy),
		.a_addr (a_addr),
		.b_addr (b_addr),
		.tag    (tag_s0)
	);

	cmmh_mem #(
		.ADDR_W (ADDR_W),
		.DATA_W (ELEM_W)
	) u_mem_a (
		.clk   (clk),
		.we    (mem_a_we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.rd_en (adv),
		.raddr (a_addr),
		.rdata (a_rd)
	);

	cmmh_mem #(
		.ADDR_W (ADDR_W),
		.DATA_W (ELEM_W)
	) u_mem_b (
		.clk   (clk),
		.we    (mem_b_we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.rd_en (adv),
		.raddr (b_addr),
		.rdata (b_rd)
	);

	cmmh_mac #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.herm_a    (dims_q.herm_a),
		.herm_b    (dims_q.herm_b),
		.tag_s0    (tag_s0),
		.a_rd      (a_rd),
		.b_rd      (b_rd),
		.out_valid (out_valid),
		.out_row   (out_row),
		.out_col   (out_col),
		.sum_re    (sum_re),
		.sum_im    (sum_im),
		.last      (last)
	);

	`CMMH_ASSERT_NEXT(a_compute_busy, clk, arst_n, start, in_stall, "compute transaction did not start a run")
	`CMMH_ASSERT_IMPL(a_no_write_in_run, clk, arst_n, busy, !mem_a_we && !mem_b_we, "store written during a run")
	`CMMH_ASSERT_NEXT(a_hold_addr, clk, arst_n, busy && !adv, $stable(a_addr) && $stable(b_addr), "read address moved under stall")

endmodule

`default_nettype wire
